/* sv/mlfq_pkg.sv */
package mlfq_pkg;

    localparam int NUM_LEVELS_DEF  = 16;
    localparam int NUM_THREADS_DEF = 16;

    localparam int MODE_W     = 3;
    localparam int THREAD_W   = 4;
    localparam int LEVEL_W    = 4;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam int GRP_SIZE  = 8;
    localparam int GRP_IDX_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_NEW     = 3'd0,
        MODE_BLOCK   = 3'd1,
        MODE_END     = 3'd2,
        MODE_UNBLOCK = 3'd3,
        MODE_TIMER   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PTR_RD,
        ST_PUSH,
        ST_SCAN,
        ST_POP_RD,
        ST_POP_A,
        ST_POP_B,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic ptr_we;
        logic store_we;
        logic store_re;
    } t_qmem_ctl;

    typedef struct packed {
        logic                none_ready;
        logic [LEVEL_W-1:0]  next_level;
        logic [THREAD_W-1:0] next_thread;
        logic [THREAD_W-1:0] old_thread;
        logic                switched;
    } t_result;

endpackage

/* sv/mlfq_qmem.sv */
module mlfq_qmem #(
    parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF,
    parameter int NUM_THREADS = mlfq_pkg::NUM_THREADS_DEF
) (
    input  logic                               i_clk,
    input  mlfq_pkg::t_qmem_ctl                i_ctl,
    input  logic [$clog2(NUM_LEVELS)-1:0]      i_lvl,
    input  logic [$clog2(NUM_THREADS)-1:0]     i_wslot,
    input  logic [$clog2(NUM_THREADS)-1:0]     i_rslot,
    input  logic [mlfq_pkg::THREAD_W-1:0]      i_st_wdata,
    input  logic [2*$clog2(NUM_THREADS)-1:0]   i_ptr_wdata,
    output logic [2*$clog2(NUM_THREADS)-1:0]   o_ptr_rdata,
    output logic [mlfq_pkg::THREAD_W-1:0]      o_st_rdata
);
    import mlfq_pkg::*;

    localparam int SLOT_W   = $clog2(NUM_THREADS);
    localparam int ST_DEPTH = NUM_LEVELS * (2 ** SLOT_W);

    logic [THREAD_W-1:0] r_store [ST_DEPTH];
    logic [2*SLOT_W-1:0] r_ptr   [NUM_LEVELS];
    logic [2*SLOT_W-1:0] r_ptr_rd;
    logic [THREAD_W-1:0] r_st_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.store_we) begin
            r_store[{i_lvl, i_wslot}] <= i_st_wdata;
        end
        if (i_ctl.store_re) begin
            r_st_rd <= r_store[{i_lvl, i_rslot}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ptr_we) begin
            r_ptr[i_lvl] <= i_ptr_wdata;
        end
        r_ptr_rd <= r_ptr[i_lvl];
    end

    assign o_ptr_rdata = r_ptr_rd;
    assign o_st_rdata  = r_st_rd;

endmodule

/* sv/mlfq_ctrl.sv */
module mlfq_ctrl #(
    parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF,
    parameter int NUM_THREADS = mlfq_pkg::NUM_THREADS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_valid,
    output logic                               o_s_ready,
    input  logic [mlfq_pkg::MODE_W-1:0]        i_mode,
    input  logic [mlfq_pkg::THREAD_W-1:0]      i_thread,
    input  logic                               i_single,
    output logic                               o_m_valid,
    input  logic                               i_m_ready,
    output mlfq_pkg::t_result                  o_result,
    output mlfq_pkg::t_qmem_ctl                o_qctl,
    output logic [$clog2(NUM_LEVELS)-1:0]      o_lvl,
    output logic [$clog2(NUM_THREADS)-1:0]     o_wslot,
    output logic [$clog2(NUM_THREADS)-1:0]     o_rslot,
    output logic [mlfq_pkg::THREAD_W-1:0]      o_st_wdata,
    output logic [2*$clog2(NUM_THREADS)-1:0]   o_ptr_wdata,
    input  logic [2*$clog2(NUM_THREADS)-1:0]   i_ptr_rdata,
    input  logic [mlfq_pkg::THREAD_W-1:0]      i_st_rdata
);
    import mlfq_pkg::*;

    localparam int LVL_W    = $clog2(NUM_LEVELS);
    localparam int SLOT_W   = $clog2(NUM_THREADS);
    localparam int TL_DEPTH = (NUM_THREADS < (1 << THREAD_W)) ? NUM_THREADS : (1 << THREAD_W);
    localparam int TL_W     = $clog2(TL_DEPTH);
    localparam int NUM_GRP  = (NUM_LEVELS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W    = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int PAD_W    = NUM_GRP * GRP_SIZE;

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_THREADS - 1)) ? '0 : SLOT_W'(s + 1'b1);
    endfunction

    t_state                r_state, n_state;
    logic [THREAD_W-1:0]   r_thread;
    logic [THREAD_W-1:0]   r_cur;
    logic                  r_switch;
    logic [LVL_W-1:0]      r_lvl;
    logic [GRP_W-1:0]      r_grp;
    logic [NUM_LEVELS-1:0] r_nonempty;
    logic [LVL_W-1:0]      r_tlevel [TL_DEPTH];
    t_result               r_res;

    logic                  w_accept;
    logic                  w_in_range;
    logic [TL_W-1:0]       w_tidx;
    logic [LVL_W-1:0]      w_tl;
    logic                  d_valid, d_push, d_switch, d_tl_we;
    logic [LVL_W-1:0]      d_lvl, d_tl_val;

    logic [SLOT_W-1:0]     w_head, w_tail, w_wslot, w_head_nx;
    logic                  w_ne, w_full;

    logic [PAD_W-1:0]      w_ne_pad;
    logic [GRP_SIZE-1:0]   w_grp_bits;
    logic                  w_hit;
    logic [GRP_IDX_W-1:0]  w_enc;
    logic [LVL_W-1:0]      w_found_lvl;
    logic                  w_last_grp;

    assign w_accept   = i_s_valid && o_s_ready;
    assign w_in_range = int'(i_thread) < NUM_THREADS;
    assign w_tidx     = i_thread[TL_W-1:0];
    assign w_tl       = r_tlevel[w_tidx];

    always_comb begin
        d_valid  = 1'b0;
        d_push   = 1'b0;
        d_switch = 1'b0;
        d_tl_we  = 1'b0;
        d_tl_val = '0;
        d_lvl    = '0;
        if (w_in_range) begin
            unique case (i_mode) inside
                MODE_NEW: begin
                    d_valid = 1'b1;
                    d_push  = 1'b1;
                    d_tl_we = 1'b1;
                end
                MODE_BLOCK, MODE_END: begin
                    d_valid  = 1'b1;
                    d_switch = 1'b1;
                end
                MODE_UNBLOCK: begin
                    d_valid = 1'b1;
                    d_push  = 1'b1;
                    d_lvl   = w_tl;
                end
                MODE_TIMER: begin
                    d_valid  = 1'b1;
                    d_push   = 1'b1;
                    d_switch = 1'b1;
                    d_tl_we  = 1'b1;
                    d_tl_val = (!i_single && w_tl != LVL_W'(NUM_LEVELS - 1)) ?
                               LVL_W'(w_tl + 1'b1) : w_tl;
                    d_lvl    = d_tl_val;
                end
                default: begin
                    d_valid = 1'b0;
                end
            endcase
        end
    end

    assign w_head    = i_ptr_rdata[2*SLOT_W-1:SLOT_W];
    assign w_tail    = i_ptr_rdata[SLOT_W-1:0];
    assign w_ne      = r_nonempty[r_lvl];
    assign w_full    = w_ne && (w_head == w_tail);
    assign w_wslot   = w_ne ? w_tail : '0;
    assign w_head_nx = slot_next(w_head);

    assign w_ne_pad   = PAD_W'(r_nonempty);
    assign w_grp_bits = w_ne_pad[r_grp*GRP_SIZE +: GRP_SIZE];
    assign w_hit      = |w_grp_bits;

    always_comb begin
        w_enc = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--) begin
            if (w_grp_bits[i]) begin
                w_enc = GRP_IDX_W'(i);
            end
        end
    end

    assign w_found_lvl = LVL_W'({r_grp, w_enc});
    assign w_last_grp  = (r_grp == GRP_W'(NUM_GRP - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!d_valid) begin
                        n_state = ST_OUT;
                    end else if (d_push) begin
                        n_state = ST_PTR_RD;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_PTR_RD: n_state = ST_PUSH;
            ST_PUSH:   n_state = r_switch ? ST_SCAN : ST_OUT;
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = ST_POP_RD;
                end else if (w_last_grp) begin
                    n_state = ST_OUT;
                end
            end
            ST_POP_RD: n_state = ST_POP_A;
            ST_POP_A:  n_state = ST_POP_B;
            ST_POP_B:  n_state = ST_OUT;
            ST_OUT: begin
                if (i_m_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready   = (r_state == ST_IDLE);
        o_m_valid   = (r_state == ST_OUT);
        o_qctl      = '0;
        o_ptr_wdata = '0;
        unique case (r_state)
            ST_PUSH: begin
                o_qctl.ptr_we   = !w_full;
                o_qctl.store_we = !w_full;
                o_ptr_wdata     = {(w_ne ? w_head : {SLOT_W{1'b0}}), slot_next(w_wslot)};
            end
            ST_POP_A: begin
                o_qctl.ptr_we   = 1'b1;
                o_qctl.store_re = 1'b1;
                o_ptr_wdata     = {w_head_nx, w_tail};
            end
            default: begin
                o_qctl = '0;
            end
        endcase
    end

    assign o_lvl      = r_lvl;
    assign o_wslot    = w_wslot;
    assign o_rslot    = w_head;
    assign o_st_wdata = r_thread;
    assign o_result   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_nonempty <= '0;
            r_cur      <= '0;
            for (int i = 0; i < TL_DEPTH; i++) begin
                r_tlevel[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && d_tl_we) begin
                        r_tlevel[w_tidx] <= d_tl_val;
                    end
                end
                ST_PUSH: begin
                    if (!w_full) begin
                        r_nonempty[r_lvl] <= 1'b1;
                    end
                end
                ST_POP_A: begin
                    if (w_head_nx == w_tail) begin
                        r_nonempty[r_lvl] <= 1'b0;
                    end
                end
                ST_POP_B: begin
                    r_cur <= i_st_rdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_thread <= i_thread;
                    r_lvl    <= d_lvl;
                    r_switch <= d_switch;
                    r_grp    <= '0;
                    r_res    <= '0;
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    r_lvl <= w_found_lvl;
                end else if (w_last_grp) begin
                    r_res.none_ready  <= 1'b1;
                    r_res.next_level  <= '0;
                    r_res.next_thread <= r_cur;
                    r_res.old_thread  <= r_cur;
                    r_res.switched    <= 1'b0;
                end else begin
                    r_grp <= GRP_W'(r_grp + 1'b1);
                end
            end
            ST_POP_B: begin
                r_res.none_ready  <= 1'b0;
                r_res.next_level  <= LEVEL_W'(r_lvl);
                r_res.next_thread <= i_st_rdata;
                r_res.old_thread  <= r_cur;
                r_res.switched    <= 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/multilevel_feedback_scheduler.sv */
// Multilevel feedback queue scheduler. Each event is a single transfer on the slave side and
// yields exactly one result transfer on the master side; the block takes no new event until that
// result has been taken. An event that only queues a thread (new, unblock) reads the pointers of
// its level and then writes the thread into the queue memory. An event that needs a switch
// (block, end) runs a priority scan over the eight-level groups, lowest levels first, until it
// finds a non-empty level, then reads that level's pointers and pops its head thread; a timer
// tick first queues the thread as above and then does the same. A block or end event that finds
// every level empty reports none_ready. The reads of the per-level pointer memory and of the
// queue memory are registered. Unknown modes and thread numbers not below NUM_THREADS return an
// all-zero result in the cycle after their transfer and leave the state untouched. No clearing
// pass is needed after reset.
module multilevel_feedback_scheduler #(
    parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF,
    parameter int NUM_THREADS = mlfq_pkg::NUM_THREADS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // thread [3:0], single_thread [4], zero [7:5]
    input  logic [mlfq_pkg::IN_DATA_W-1:0]      s_tdata,
    // mode [2:0]
    input  logic [mlfq_pkg::MODE_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // switched [0], old_thread [4:1], next_thread [8:5], next_level [12:9],
    // none_ready [13], zero [15:14]
    output logic [mlfq_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import mlfq_pkg::*;

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int SLOT_W = $clog2(NUM_THREADS);

    t_result             w_result;
    t_qmem_ctl           w_qctl;
    logic [LVL_W-1:0]    w_lvl;
    logic [SLOT_W-1:0]   w_wslot, w_rslot;
    logic [THREAD_W-1:0] w_st_wdata, w_st_rdata;
    logic [2*SLOT_W-1:0] w_ptr_wdata, w_ptr_rdata;

    mlfq_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .NUM_THREADS (NUM_THREADS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_tvalid),
        .o_s_ready   (s_tready),
        .i_mode      (s_tuser),
        .i_thread    (s_tdata[THREAD_W-1:0]),
        .i_single    (s_tdata[THREAD_W]),
        .o_m_valid   (m_tvalid),
        .i_m_ready   (m_tready),
        .o_result    (w_result),
        .o_qctl      (w_qctl),
        .o_lvl       (w_lvl),
        .o_wslot     (w_wslot),
        .o_rslot     (w_rslot),
        .o_st_wdata  (w_st_wdata),
        .o_ptr_wdata (w_ptr_wdata),
        .i_ptr_rdata (w_ptr_rdata),
        .i_st_rdata  (w_st_rdata)
    );

    mlfq_qmem #(
        .NUM_LEVELS  (NUM_LEVELS),
        .NUM_THREADS (NUM_THREADS)
    ) u_qmem (
        .i_clk       (i_clk),
        .i_ctl       (w_qctl),
        .i_lvl       (w_lvl),
        .i_wslot     (w_wslot),
        .i_rslot     (w_rslot),
        .i_st_wdata  (w_st_wdata),
        .i_ptr_wdata (w_ptr_wdata),
        .o_ptr_rdata (w_ptr_rdata),
        .o_st_rdata  (w_st_rdata)
    );

    assign m_tdata = OUT_DATA_W'(w_result);

endmodule

/* sv/mlfq_checker.sv */
module mlfq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mlfq_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic [mlfq_pkg::MODE_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mlfq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mlfq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed or vanished while stalled.");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("A second event was taken while one was in progress.");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !m_tvalid)
        else $error("Ready for an event while a result is still waiting.");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[13]))
        else $error("Switched and none_ready reported together.");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[13] |-> (m_tdata[4:1] == m_tdata[8:5]) && (m_tdata[12:9] == '0))
        else $error("Empty search result does not keep the running thread.");

endmodule

bind multilevel_feedback_scheduler mlfq_checker u_mlfq_checker (.*);

/* sim/tb_multilevel_feedback_scheduler.sv */
module tb_multilevel_feedback_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfq_pkg::*;

    localparam int LEVELS  = NUM_LEVELS_DEF;
    localparam int THREADS = NUM_THREADS_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
    localparam int PHASE_EVENTS = 450;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int src_gap_pct = 15;
    int sink_gap_pct = 71;
    int mismatches = 0;
    int events_counted = 0;

    logic [THREAD_W-1:0] ready_slots [LEVELS][THREADS];
    int                  ready_head  [LEVELS];
    int                  ready_tail  [LEVELS];
    int                  ready_count [LEVELS];
    logic [LEVEL_W-1:0]  level_of    [THREADS];
    logic [THREAD_W-1:0] running_thread;

    t_result switch_results [$];

    multilevel_feedback_scheduler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic void enqueue_ready(int lvl, logic [THREAD_W-1:0] thr);
        if (ready_count[lvl] < THREADS) begin
            ready_slots[lvl][ready_tail[lvl]] = thr;
            ready_tail[lvl] = (ready_tail[lvl] + 1) % THREADS;
            ready_count[lvl]++;
        end
    endfunction

    function automatic t_result schedule_event(logic [MODE_W-1:0] mode,
                                               logic [THREAD_W-1:0] thr, bit single);
        t_result r;
        bit      do_switch;
        int      lvl;
        r = '0;
        do_switch = 1'b0;
        if (mode > MODE_TIMER) begin
            return r;
        end
        case (mode)
            MODE_NEW: begin
                level_of[thr] = '0;
                enqueue_ready(0, thr);
            end
            MODE_BLOCK, MODE_END: begin
                do_switch = 1'b1;
            end
            MODE_UNBLOCK: begin
                enqueue_ready(int'(level_of[thr]), thr);
            end
            default: begin
                if (!single && level_of[thr] < LEVELS - 1) begin
                    level_of[thr] = level_of[thr] + 1'b1;
                end
                enqueue_ready(int'(level_of[thr]), thr);
                do_switch = 1'b1;
            end
        endcase
        if (!do_switch) begin
            return r;
        end
        lvl = 0;
        while (lvl < LEVELS && ready_count[lvl] == 0) begin
            lvl++;
        end
        r.old_thread = running_thread;
        if (lvl == LEVELS) begin
            r.next_thread = running_thread;
            r.none_ready = 1'b1;
            return r;
        end
        r.switched = 1'b1;
        r.next_thread = ready_slots[lvl][ready_head[lvl]];
        r.next_level = lvl[LEVEL_W-1:0];
        ready_head[lvl] = (ready_head[lvl] + 1) % THREADS;
        ready_count[lvl]--;
        running_thread = r.next_thread;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_sink
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_result'(m_tdata[$bits(t_result)-1:0]);
                if (switch_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none got %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = switch_results.pop_front();
                    check_field("switched", int'(want.switched), int'(got.switched));
                    check_field("old_thread", int'(want.old_thread), int'(got.old_thread));
                    check_field("next_thread", int'(want.next_thread), int'(got.next_thread));
                    check_field("next_level", int'(want.next_level), int'(got.next_level));
                    check_field("none_ready", int'(want.none_ready), int'(got.none_ready));
                end
            end
            m_tready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    task automatic send_event(input logic [MODE_W-1:0] mode, input logic [THREAD_W-1:0] thr,
                              input bit single);
        if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, single, thr};
        do @(posedge i_clk); while (!s_tready);
        switch_results.push_back(schedule_event(mode, thr, single));
        if (mode <= MODE_TIMER) begin
            events_counted++;
        end
    endtask

    task automatic wait_all_results(input int max_cycles);
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (switch_results.size() != 0 && waited < max_cycles);
        if (switch_results.size() != 0) begin
            $display("%0t: %0d results expected but never transferred", $time,
                     switch_results.size());
            mismatches++;
            switch_results.delete();
        end
    endtask

    task automatic test_empty_search_and_ignored();
        send_event(MODE_BLOCK, 4'd0, 1'b0);
        send_event(MODE_END, 4'd15, 1'b1);
        send_event(MODE_UNUSED_LO, 4'd15, 1'b1);
        send_event(MODE_UNUSED_LO + 3'd1, 4'd10, 1'b0);
        send_event(MODE_UNUSED_HI, 4'd0, 1'b1);
        send_event(MODE_NEW, 4'd15, 1'b0);
        send_event(MODE_NEW, 4'd0, 1'b1);
        send_event(MODE_NEW, 4'd9, 1'b0);
        send_event(MODE_BLOCK, 4'd9, 1'b0);
        send_event(MODE_TIMER, 4'd15, 1'b1);
        send_event(MODE_TIMER, 4'd0, 1'b0);
        send_event(MODE_UNBLOCK, 4'd0, 1'b0);
        send_event(MODE_END, 4'd9, 1'b0);
        send_event(MODE_BLOCK, 4'd15, 1'b0);
        send_event(MODE_END, 4'd0, 1'b0);
        send_event(MODE_END, 4'd0, 1'b1);
    endtask

    task automatic test_full_ready_queue();
        for (int i = 0; i <= THREADS; i++) begin
            send_event(MODE_NEW, i[THREAD_W-1:0], i[0]);
        end
        for (int i = 0; i <= THREADS; i++) begin
            send_event(MODE_END, 4'd4, 1'b0);
        end
    endtask

    task automatic test_demote_to_last_level();
        send_event(MODE_NEW, 4'd7, 1'b0);
        for (int i = 0; i < LEVELS; i++) begin
            send_event(MODE_TIMER, 4'd7, 1'b0);
        end
        send_event(MODE_UNBLOCK, 4'd7, 1'b0);
        send_event(MODE_END, 4'd7, 1'b0);
        send_event(MODE_END, 4'd7, 1'b0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        int stop_at;
        int pick;
        int len;
        logic [THREAD_W-1:0] thr;
        src_gap_pct = src_pct;
        sink_gap_pct = sink_pct;
        stop_at = events_counted + count;
        while (events_counted < stop_at) begin
            pick = $urandom_range(99);
            thr = THREAD_W'($urandom_range(THREADS - 1));
            if (pick < 25) begin
                len = $urandom_range(6, 1);
                repeat (len) send_event(MODE_NEW, THREAD_W'($urandom_range(THREADS - 1)),
                                        1'($urandom_range(1)));
            end else if (pick < 50) begin
                len = $urandom_range(18, 1);
                repeat (len) send_event(MODE_TIMER, thr, $urandom_range(9) == 0);
            end else if (pick < 80) begin
                send_event($urandom_range(1) ? MODE_BLOCK : MODE_END, thr,
                           1'($urandom_range(1)));
                len = $urandom_range(3, 1);
                repeat (len) send_event(MODE_UNBLOCK, THREAD_W'($urandom_range(THREADS - 1)),
                                        1'($urandom_range(1)));
            end else if (pick < 92) begin
                len = $urandom_range(4, 1);
                repeat (len) send_event(MODE_W'($urandom_range(MODE_TIMER)),
                                        THREAD_W'($urandom_range(THREADS - 1)),
                                        1'($urandom_range(1)));
            end else begin
                len = $urandom_range(2, 1);
                repeat (len) send_event(MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO)),
                                        THREAD_W'($urandom_range(THREADS - 1)),
                                        1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        for (int l = 0; l < LEVELS; l++) begin
            ready_head[l] = 0;
            ready_tail[l] = 0;
            ready_count[l] = 0;
            for (int t = 0; t < THREADS; t++) begin
                ready_slots[l][t] = '0;
            end
        end
        for (int t = 0; t < THREADS; t++) begin
            level_of[t] = '0;
        end
        running_thread = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_search_and_ignored();
        test_full_ready_queue();
        test_demote_to_last_level();
        test_random_traffic(15, 71, PHASE_EVENTS);
        wait_all_results(10000);
        test_random_traffic(71, 15, PHASE_EVENTS);
        wait_all_results(10000);
        test_random_traffic(0, 0, PHASE_EVENTS);
        wait_all_results(10000);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
